// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define ASSERT_CLKD(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLKD(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== design/ise_pkg.sv =====
// ----------------------------------------------------------------------------
// ise_pkg
// Shared types and constants of the interpolation search engine.
// ----------------------------------------------------------------------------
package ise_pkg;

  localparam int KEY_W   = 32;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [INDEX_W-1:0]       entry_index;
    logic signed [KEY_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] position;
  } out_item_t;

endpackage

// ===== design/ise_ram.sv =====
// ----------------------------------------------------------------------------
// ise_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ise_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/interpolation_search_engine_core.sv =====
// ----------------------------------------------------------------------------
// interpolation_search_engine_core
// Sorted-table interpolation search with one shared multiply/divide datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carries items. kind = write stores value at
//   entry_index (no result; indexes at or above TABLE_DEPTH are
//   dropped). kind = search looks up value among the first used_count
//   entries and gives one out transaction {found, position}.
//   cfg_wr_en/cfg_wr_data set used_count; write it only while idle.
// Sequence:
//   A search probe steps through reads of t[low] and t[high], compare,
//   multiply, the divider (a load, then IW quotient bits at one bit a cycle,
//   IW = log2(TABLE_DEPTH), 10 at 1024 entries), probe read and compare; an
//   equal-ends probe skips multiply and divider. The single RAM read port and
//   the bit-serial divider set the length of a probe. Input stall stays
//   high for the whole search and while its result waits for the out slot.
// Reset: synchronous; clears the sequencer, out_valid and used_count. Table
//   contents are undefined until written.
// Output stall: the result sits in the output register; further writes are
//   still taken, a new search runs but holds its result until the slot frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module interpolation_search_engine_core #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [ise_pkg::COUNT_W-1:0]      cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ise_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ise_pkg::out_item_t               out_data
);

  import ise_pkg::*;

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int LW  = IW + 2;
  localparam int CW  = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;
  localparam int SW  = (ELEMENT_WIDTH < KEY_W) ? ELEMENT_WIDTH : KEY_W;
  localparam int XW  = (IW > INDEX_W) ? IW + 1 : INDEX_W + 1;
  localparam int PW  = (IW > INDEX_W) ? IW : INDEX_W;
  localparam int DCW = $clog2(IW + 1);
  localparam int MW  = KEY_W + IW;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOP, S_READ_HI, S_CMP, S_MUL, S_DIV, S_PRD, S_PROBE, S_DONE
  } state_t;

  state_t                 state;
  logic [COUNT_W-1:0]     used_count;
  logic [KEY_W-1:0]       key;
  logic signed [LW-1:0]   low;
  logic signed [LW-1:0]   high;
  logic [KEY_W-1:0]       lo_v;
  logic [KEY_W-1:0]       kdiff;
  logic [KEY_W-1:0]       span;
  logic [IW-1:0]          rng;
  logic [MW-1:0]          prod;
  logic [KEY_W-1:0]       rem;
  logic [IW-1:0]          dsh;
  logic [DCW-1:0]         dcnt;
  logic [IW-1:0]          pos;
  logic                   res_found;
  logic [IW-1:0]          res_pos;

  // datapath wires
  logic                   in_acc;
  logic                   wr_en;
  logic [XW-1:0]          idx_x;
  logic [IW-1:0]          rd_addr;
  logic [SW-1:0]          rd_data;
  logic signed [SW-1:0]   rd_s;
  logic [KEY_W-1:0]       rd_ext;
  logic [KEY_W-1:0]       rd_b;
  logic [KEY_W-1:0]       key_in_b;
  logic [CW-1:0]          cnt_c;
  logic [IW:0]            n_t;
  logic [KEY_W:0]         rem2;
  logic                   qbit;
  logic [KEY_W:0]         rem_sub;
  logic [IW-1:0]          dsh_next;
  logic signed [LW-1:0]   pos_s;
  logic [PW-1:0]          pos_wide;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign idx_x    = XW'(in_data.entry_index);
  assign wr_en    = in_acc && (in_data.kind == KIND_WRITE) && (idx_x < XW'(TABLE_DEPTH));

  // offset-binary form: unsigned compare gives signed order
  assign rd_s     = $signed(rd_data);
  assign rd_ext   = KEY_W'(rd_s);
  assign rd_b     = {~rd_ext[KEY_W-1], rd_ext[KEY_W-2:0]};
  assign key_in_b = {~in_data.value[KEY_W-1], in_data.value[KEY_W-2:0]};

  // effective count, clipped to table depth
  assign cnt_c = CW'(used_count);
  assign n_t   = (cnt_c > CW'(TABLE_DEPTH)) ? (IW + 1)'(TABLE_DEPTH) : (IW + 1)'(cnt_c);

  // restoring divider step: one quotient bit per cycle
  assign rem2     = {rem, dsh[IW-1]};
  assign qbit     = (rem2 >= {1'b0, span});
  assign rem_sub  = qbit ? (rem2 - {1'b0, span}) : rem2;
  assign dsh_next = (dsh << 1) | IW'(qbit);

  assign pos_s    = $signed({2'b00, pos});
  assign pos_wide = PW'(res_pos);

  always_comb begin
    case (state)
      S_LOOP:    rd_addr = low[IW-1:0];
      S_READ_HI: rd_addr = high[IW-1:0];
      S_PRD:     rd_addr = pos;
      default:   rd_addr = low[IW-1:0];
    endcase
  end

  ise_ram #(
    .WIDTH (SW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_x[IW-1:0]),
    .wr_data (in_data.value[SW-1:0]),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      used_count <= '0;
    end else begin
      if (cfg_wr_en) begin
        used_count <= cfg_wr_data;
      end
      // S_DONE reloads the slot itself in the cycle it frees
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && (in_data.kind == KIND_SEARCH)) begin
            key       <= key_in_b;
            low       <= '0;
            high      <= $signed({1'b0, n_t}) - LW'(1);
            res_found <= 1'b0;
            res_pos   <= '0;
            state     <= S_LOOP;
          end
        end
        S_LOOP: begin
          // read of t[low] issued here
          if (low <= high) begin
            state <= S_READ_HI;
          end else begin
            state <= S_DONE;
          end
        end
        S_READ_HI: begin
          lo_v  <= rd_b;
          state <= S_CMP;
        end
        S_CMP: begin
          if ((key >= lo_v) && (key <= rd_b)) begin
            kdiff <= key - lo_v;
            span  <= rd_b - lo_v;
            rng   <= IW'(high - low);
            if (rd_b == lo_v) begin
              pos   <= low[IW-1:0];
              state <= S_PRD;
            end else begin
              state <= S_MUL;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_MUL: begin
          prod  <= MW'(kdiff) * MW'(rng);
          state <= S_DIV;
          dcnt  <= DCW'(IW);
        end
        S_DIV: begin
          if (dcnt == DCW'(IW)) begin
            // quotient fits IW bits, so the top word starts below span
            rem <= prod[MW-1:IW];
            dsh <= prod[IW-1:0];
          end else begin
            rem <= rem_sub[KEY_W-1:0];
            dsh <= dsh_next;
          end
          dcnt <= dcnt - DCW'(1);
          if (dcnt == '0) begin
            pos   <= low[IW-1:0] + dsh_next;
            state <= S_PRD;
          end
        end
        S_PRD: begin
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (rd_b == key) begin
            res_found <= 1'b1;
            res_pos   <= pos;
            state     <= S_DONE;
          end else begin
            if (rd_b < key) begin
              low <= pos_s + LW'(1);
            end else begin
              high <= pos_s - LW'(1);
            end
            state <= S_LOOP;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid         <= 1'b1;
            out_data.found    <= res_found;
            out_data.position <= pos_wide[INDEX_W-1:0];
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // divider loop: one load, then IW quotient steps
  `ASSERT_CLKD(a_probe_in_range, clk, rst, (state == S_PRD) |-> ((pos_s >= low) && (pos_s <= high)))
  `ASSERT_CLKD(a_div_rem_below_span, clk, rst, ((state == S_DIV) && (dcnt != DCW'(IW))) |-> (rem < span))
  `ASSERT_NEVER(a_miss_with_position, clk, rst, out_valid && !out_data.found && (out_data.position != '0))

endmodule
